[hw/rtl/touch_frame_parser_macros.svh]
// Assertion helpers for the touch frame parser.
// Both sample on aclk and are disabled while aresetn is low.
`ifndef TOUCH_FRAME_PARSER_MACROS_SVH
`define TOUCH_FRAME_PARSER_MACROS_SVH

// Same-cycle implication.
`define TFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("touch_frame_parser: same-cycle check failed");

// Next-cycle implication.
`define TFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("touch_frame_parser: next-cycle check failed");

`endif

[hw/rtl/tfp_pkg.sv]
`timescale 1ns / 1ps

package tfp_pkg;

    localparam int DIGITS_PER_AXIS = 4;   // 1..4
    localparam int DIGIT_SLOTS     = 4;
    localparam int IDX_W           = 2;
    localparam int BYTE_W          = 8;
    localparam int COORD_W         = 21;
    localparam int PHASE_W         = 3;

    localparam logic [BYTE_W-1:0] HDR_CHAR     = 8'd65;   // 'A'
    localparam logic [BYTE_W-1:0] ALPHA_OFFSET = 8'd55;
    localparam logic [BYTE_W-1:0] DIGIT_OFFSET = 8'd48;   // '0'

    localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(DIGITS_PER_AXIS - 1);
    localparam logic [IDX_W-1:0] PRESS_KEEP = 2'd1;
    localparam logic [IDX_W-1:0] PRESS_LAST = 2'd2;

    localparam int TDATA_W = ((2 * COORD_W + BYTE_W + 7) / 8) * 8;
    localparam int PAD_W   = TDATA_W - 2 * COORD_W - BYTE_W;

    typedef logic [DIGIT_SLOTS-1:0][BYTE_W-1:0] digit_vec_t;

    function automatic logic [BYTE_W-1:0] to_digit(input logic [BYTE_W-1:0] c);
        if (c < HDR_CHAR) begin
            return c - DIGIT_OFFSET;
        end
        return c - ALPHA_OFFSET;
    endfunction

    // Hex-style weighting: first digit most significant.
    function automatic logic [COORD_W-1:0] weigh(input digit_vec_t d);
        logic [COORD_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < DIGITS_PER_AXIS; i++) begin
            acc = (acc << 4) + COORD_W'(d[i]);
        end
        return acc;
    endfunction

endpackage

[hw/rtl/touch_frame_parser.sv]
`timescale 1ns / 1ps
// Touch frame parser.
// s_axis: one received serial byte per beat (s_tdata[7:0] = rx_byte).
// m_axis: one beat per complete frame whose press value differs from the
//   no-touch code; m_tdata carries x_coord, y_coord and touch_value.
// cfg_wr_en/cfg_wr_data write touch_none_code; write it while the block is idle.
// Frame: 'A', 'A' (other bytes between are skipped), four X characters,
//   four Y characters, three press characters; the second press character
//   minus '0' is the press value.
// Throughput: one byte per cycle. Latency: the result beat is valid in the
//   cycle after the last press character is accepted (one output register).
// The result register holds its beat while m_tready is low; bytes keep
//   flowing in meanwhile. Only the last byte of a frame waits, when the
//   output register is still full and not being drained.
// Reset (aresetn low, synchronous): parser back to waiting for the first
//   header byte, output empty, no-touch code cleared to 0. Digit stores
//   are not reset; every frame writes them before use.
`include "touch_frame_parser_macros.svh"

module touch_frame_parser
    import tfp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [BYTE_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,    // [7:0] rx_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata     // [20:0] x_coord, [41:21] y_coord,
                                            // [49:42] touch_value, rest zero
);

    localparam logic [PHASE_W-1:0] PH_WAIT_A1 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_A2 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_X       = 3'd2;
    localparam logic [PHASE_W-1:0] PH_Y       = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PRESS   = 3'd4;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    digit_vec_t         x_dig_reg, y_dig_reg;
    logic [BYTE_W-1:0]  press_reg;
    logic [BYTE_W-1:0]  none_code_reg;

    logic               m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] m_x_reg, m_y_reg;
    logic [BYTE_W-1:0]  m_touch_reg;

    logic               s_acc;
    logic               frame_end;
    logic               emit;
    logic [BYTE_W-1:0]  digit;

    assign frame_end = (phase_reg == PH_PRESS) && (idx_reg >= PRESS_LAST);
    assign s_tready  = !(frame_end && m_valid_reg && !m_tready);
    assign s_acc     = s_tvalid && s_tready;
    assign emit      = s_acc && frame_end && (press_reg != none_code_reg);
    assign digit     = to_digit(s_tdata);

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (s_acc) begin
            case (phase_reg)
                PH_WAIT_A2: begin
                    if (s_tdata == HDR_CHAR) begin
                        phase_next = PH_X;
                    end
                end
                PH_X: begin
                    if (idx_reg >= LAST_DIGIT) begin
                        phase_next = PH_Y;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                PH_Y: begin
                    if (idx_reg >= LAST_DIGIT) begin
                        phase_next = PH_PRESS;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                PH_PRESS: begin
                    if (idx_reg >= PRESS_LAST) begin
                        phase_next = PH_WAIT_A1;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                default: begin
                    phase_next = (s_tdata == HDR_CHAR) ? PH_WAIT_A2 : PH_WAIT_A1;
                    idx_next   = '0;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT_A1;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
            none_code_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                none_code_reg <= cfg_wr_data;
            end
        end
    end

    // Digit and press stores, written only inside a frame, and the result register, loaded on emit; no reset.
    always_ff @(posedge aclk) begin
        if (s_acc && phase_reg == PH_X) begin
            x_dig_reg[idx_reg] <= digit;
        end
        if (s_acc && phase_reg == PH_Y) begin
            y_dig_reg[idx_reg] <= digit;
        end
        if (s_acc && phase_reg == PH_PRESS && idx_reg == PRESS_KEEP) begin
            press_reg <= s_tdata - DIGIT_OFFSET;
        end
        if (emit) begin
            m_x_reg     <= weigh(x_dig_reg);
            m_y_reg     <= weigh(y_dig_reg);
            m_touch_reg <= press_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {PAD_W'(0), m_touch_reg, m_y_reg, m_x_reg};

    `TFP_ASSERT_NOW(a_rise_from_frame_end, $rose(m_valid_reg), $past(emit))
    `TFP_ASSERT_NEXT(a_emit_loads, emit, m_valid_reg && m_touch_reg != $past(none_code_reg))
    `TFP_ASSERT_NOW(a_idx_idle_zero, phase_reg == PH_WAIT_A1 || phase_reg == PH_WAIT_A2,
                    idx_reg == '0)
    `TFP_ASSERT_NOW(a_stall_only_full, !s_tready, m_valid_reg && !m_tready)

endmodule
